/* rtl/bqc_pkg.sv */
// Package for the biquad cascade low-pass filter: widths, register indexes,
// reset coefficients, datapath command codes and the shared structs.
// Depends on nothing; every other file of the block imports it.
package bqc_pkg;

  localparam int SECTIONS    = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 32;
  localparam int FRAC_BITS   = 28;
  localparam int DELAY_BITS  = 48;
  localparam int HALF_BITS   = DELAY_BITS / 2;
  localparam int OPND_BITS   = HALF_BITS + 1;
  localparam int PROD_BITS   = COEFF_BITS + OPND_BITS;
  localparam int ACC_BITS    = 84;
  localparam int RND_BITS    = ACC_BITS - FRAC_BITS;
  localparam int SEC_BITS    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int REG_COUNT   = 5;
  localparam int IDX_BITS    = 3;

  // Configuration register indexes, also used as coefficient selects.
  localparam logic [IDX_BITS-1:0] REG_A1 = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_A2 = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_B0 = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_B1 = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_B2 = 3'd4;

  localparam logic signed [COEFF_BITS-1:0] A1_RESET = 32'sd513121955;
  localparam logic signed [COEFF_BITS-1:0] A2_RESET = -32'sd245701022;
  localparam logic signed [COEFF_BITS-1:0] B0_RESET = 32'sd253633;
  localparam logic signed [COEFF_BITS-1:0] B1_RESET = 32'sd507266;
  localparam logic signed [COEFF_BITS-1:0] B2_RESET = 32'sd253633;

  // Datapath operations.
  localparam logic [2:0] OP_NOP      = 3'd0;
  localparam logic [2:0] OP_LOAD_IN  = 3'd1;
  localparam logic [2:0] OP_LOAD_SEC = 3'd2;
  localparam logic [2:0] OP_MUL      = 3'd3;
  localparam logic [2:0] OP_ROUND_W  = 3'd4;
  localparam logic [2:0] OP_ROUND_Y  = 3'd5;
  localparam logic [2:0] OP_EMIT     = 3'd6;

  // Multiplier operand selects.
  localparam logic [1:0] OPND_D1 = 2'd0;
  localparam logic [1:0] OPND_D2 = 2'd1;
  localparam logic [1:0] OPND_W0 = 2'd2;

  typedef struct packed {
    logic [2:0]          op;
    logic [IDX_BITS-1:0] coef_sel;
    logic [1:0]          opnd_sel;
    logic                hi;
    logic [SEC_BITS-1:0] sec;
  } cmd_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_BITS-1:0]   idx;
    logic [COEFF_BITS-1:0] data;
  } cfg_wr_t;

endpackage

/* rtl/bqc_in_if.sv */
// Input sample channel of the biquad cascade: valid, ready and one sample.
// Depends on bqc_pkg for the sample width.
interface bqc_in_if import bqc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

/* rtl/bqc_out_if.sv */
// Result channel of the biquad cascade: valid, ready and one filtered sample.
// Depends on bqc_pkg for the sample width.
interface bqc_out_if import bqc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

/* rtl/bqc_cfg_if.sv */
// Coefficient write channel of the biquad cascade: valid, ready, index, data.
// Depends on bqc_pkg for the index and coefficient widths.
interface bqc_cfg_if import bqc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IDX_BITS-1:0]   reg_index;
  logic [COEFF_BITS-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/biquad_cascade_lowpass.sv */
// Top level of the biquad cascade low-pass filter: four direct form II
// sections sharing one multiplier. Uses bqc_pkg, the three channel
// interfaces, bqc_ctrl and bqc_dpath.
//
// Usage: each request on in_chan carries one signed 24-bit sample; the block
// returns exactly one filtered, saturated sample on out_chan per request.
// Coefficients in signed Q4.28 are written on cfg_chan (index 0 to 4: a1, a2,
// b0, b1, b2) while no sample is in flight; other indexes are ignored and
// cfg_chan is always ready.
// Schedule: a sample is accepted while the block is idle, then every section
// runs ten half-width multiplies on the one 32 x 25 multiplier, two
// accumulator drains, two roundings and a delay fetch. The result is then
// presented and the next sample may be accepted once it is; the block takes
// no new sample before the last is through, since the multiplier is shared.
// Reset clears both delay words of every section and restores the default
// coefficients. If the receiver stalls, the finished result waits in the
// output register while the next sample is processed; that sample's result
// then waits until the register has been taken.
module biquad_cascade_lowpass import bqc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bqc_in_if.sink    in_chan,
  bqc_out_if.source out_chan,
  bqc_cfg_if.sink   cfg_chan
);

  cmd_t    cmd;
  cfg_wr_t cfg_wr;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr.we      = cfg_chan.valid;
  assign cfg_wr.idx     = cfg_chan.reg_index;
  assign cfg_wr.data    = cfg_chan.wdata;

  bqc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  bqc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .sample_in  (in_chan.sample_in),
    .cmd        (cmd),
    .sample_out (out_chan.sample_out)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("Input accepted again while a sample is in flight.");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (!out_chan.valid || out_chan.ready))
    else $error("Result overwrote an output register that was not taken.");

  a_no_mul_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (cmd.op == OP_NOP || cmd.op == OP_LOAD_IN))
    else $error("Datapath command issued while the sequencer is idle.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("Result valid directly after reset.");
`endif

endmodule

/* rtl/bqc_ctrl.sv */
// Sequencer of the biquad cascade: request handshakes and the per-section
// schedule of multiply, round and delay update commands. Uses bqc_pkg.
module bqc_ctrl import bqc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [3:0] STEP_LOAD    = 4'd0;
  localparam logic [3:0] STEP_A1_LO   = 4'd1;
  localparam logic [3:0] STEP_A1_HI   = 4'd2;
  localparam logic [3:0] STEP_A2_LO   = 4'd3;
  localparam logic [3:0] STEP_A2_HI   = 4'd4;
  localparam logic [3:0] STEP_DRAIN_W = 4'd5;
  localparam logic [3:0] STEP_ROUND_W = 4'd6;
  localparam logic [3:0] STEP_B0_LO   = 4'd7;
  localparam logic [3:0] STEP_B0_HI   = 4'd8;
  localparam logic [3:0] STEP_B1_LO   = 4'd9;
  localparam logic [3:0] STEP_B1_HI   = 4'd10;
  localparam logic [3:0] STEP_B2_LO   = 4'd11;
  localparam logic [3:0] STEP_B2_HI   = 4'd12;
  localparam logic [3:0] STEP_DRAIN_Y = 4'd13;
  localparam logic [3:0] STEP_ROUND_Y = 4'd14;

  logic [1:0]          state_r, state_nxt;
  logic [3:0]          step_r, step_nxt;
  logic [SEC_BITS-1:0] sec_r, sec_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                emit_fire;
  cmd_t                run_cmd;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    run_cmd          = '0;
    run_cmd.op       = OP_MUL;
    run_cmd.sec      = sec_r;
    case (step_r)
      STEP_LOAD: begin
        run_cmd.op = OP_LOAD_SEC;
      end
      STEP_A1_LO: begin
        run_cmd.coef_sel = REG_A1;
        run_cmd.opnd_sel = OPND_D1;
      end
      STEP_A1_HI: begin
        run_cmd.coef_sel = REG_A1;
        run_cmd.opnd_sel = OPND_D1;
        run_cmd.hi       = 1'b1;
      end
      STEP_A2_LO: begin
        run_cmd.coef_sel = REG_A2;
        run_cmd.opnd_sel = OPND_D2;
      end
      STEP_A2_HI: begin
        run_cmd.coef_sel = REG_A2;
        run_cmd.opnd_sel = OPND_D2;
        run_cmd.hi       = 1'b1;
      end
      STEP_DRAIN_W: begin
        run_cmd.op = OP_NOP;
      end
      STEP_ROUND_W: begin
        run_cmd.op = OP_ROUND_W;
      end
      STEP_B0_LO: begin
        run_cmd.coef_sel = REG_B0;
        run_cmd.opnd_sel = OPND_W0;
      end
      STEP_B0_HI: begin
        run_cmd.coef_sel = REG_B0;
        run_cmd.opnd_sel = OPND_W0;
        run_cmd.hi       = 1'b1;
      end
      STEP_B1_LO: begin
        run_cmd.coef_sel = REG_B1;
        run_cmd.opnd_sel = OPND_D1;
      end
      STEP_B1_HI: begin
        run_cmd.coef_sel = REG_B1;
        run_cmd.opnd_sel = OPND_D1;
        run_cmd.hi       = 1'b1;
      end
      STEP_B2_LO: begin
        run_cmd.coef_sel = REG_B2;
        run_cmd.opnd_sel = OPND_D2;
      end
      STEP_B2_HI: begin
        run_cmd.coef_sel = REG_B2;
        run_cmd.opnd_sel = OPND_D2;
        run_cmd.hi       = 1'b1;
      end
      STEP_DRAIN_Y: begin
        run_cmd.op = OP_NOP;
      end
      STEP_ROUND_Y: begin
        run_cmd.op = OP_ROUND_Y;
      end
      default: begin
        run_cmd.op = OP_NOP;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    sec_nxt       = sec_r;
    out_valid_nxt = (out_valid_r && !out_ready) || emit_fire;
    cmd           = '0;
    cmd.op        = OP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD_IN;
          state_nxt = ST_RUN;
          step_nxt  = STEP_LOAD;
          sec_nxt   = '0;
        end
      end
      ST_RUN: begin
        cmd = run_cmd;
        if (step_r == STEP_ROUND_Y) begin
          step_nxt = STEP_LOAD;
          if (sec_r == SEC_BITS'(SECTIONS - 1)) begin
            state_nxt = ST_EMIT;
          end else begin
            sec_nxt = sec_r + 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          cmd.op    = OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_LOAD;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/bqc_dpath.sv */
// Datapath of the biquad cascade: coefficient registers, delay words, one
// shared 32 x 25 multiplier, an accumulator and the round/saturate logic.
// Uses bqc_pkg; driven by commands from bqc_ctrl.
module bqc_dpath import bqc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_wr_t                       cfg_wr,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  cmd_t                          cmd,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  logic signed [COEFF_BITS-1:0]  coef_r [REG_COUNT];
  logic signed [DELAY_BITS-1:0]  delay_first_r [SECTIONS];
  logic signed [DELAY_BITS-1:0]  delay_second_r [SECTIONS];
  logic signed [DELAY_BITS-1:0]  d1_r, d2_r, w0_r;
  logic signed [SAMPLE_BITS-1:0] x_r, sample_out_r;
  logic signed [ACC_BITS-1:0]    acc_r;
  logic signed [PROD_BITS-1:0]   prod_r;
  logic                          prod_vld_r, prod_hi_r;

  logic signed [COEFF_BITS-1:0]  coef_mux;
  logic signed [DELAY_BITS-1:0]  word_mux;
  logic signed [OPND_BITS-1:0]   opnd;
  logic signed [PROD_BITS-1:0]   prod_nxt;
  logic signed [ACC_BITS-1:0]    prod_ext, acc_sum, rnd;
  logic signed [RND_BITS-1:0]    rsh;
  logic signed [DELAY_BITS-1:0]  w0_sat;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  assign sample_out = sample_out_r;

  always_comb begin
    case (cmd.coef_sel)
      REG_A1:  coef_mux = coef_r[0];
      REG_A2:  coef_mux = coef_r[1];
      REG_B0:  coef_mux = coef_r[2];
      REG_B1:  coef_mux = coef_r[3];
      REG_B2:  coef_mux = coef_r[4];
      default: coef_mux = '0;
    endcase
    case (cmd.opnd_sel)
      OPND_D1: word_mux = d1_r;
      OPND_D2: word_mux = d2_r;
      OPND_W0: word_mux = w0_r;
      default: word_mux = '0;
    endcase
  end

  // The delay word is split into a signed upper half and an unsigned lower half.
  assign opnd = cmd.hi ? OPND_BITS'($signed(word_mux[DELAY_BITS-1:HALF_BITS]))
                       : $signed({1'b0, word_mux[HALF_BITS-1:0]});
  assign prod_nxt = coef_mux * opnd;

  assign prod_ext = prod_hi_r ? (ACC_BITS'(prod_r) <<< HALF_BITS) : ACC_BITS'(prod_r);
  assign acc_sum  = acc_r + prod_ext;

  assign rnd = acc_r + (ACC_BITS'(1) <<< (FRAC_BITS - 1));
  assign rsh = rnd[ACC_BITS-1:FRAC_BITS];

  always_comb begin
    if (rsh[RND_BITS-1:DELAY_BITS-1] != {(RND_BITS-DELAY_BITS+1){rsh[RND_BITS-1]}}) begin
      w0_sat = rsh[RND_BITS-1] ? {1'b1, {(DELAY_BITS-1){1'b0}}}
                               : {1'b0, {(DELAY_BITS-1){1'b1}}};
    end else begin
      w0_sat = rsh[DELAY_BITS-1:0];
    end
    if (rsh[RND_BITS-1:SAMPLE_BITS-1] != {(RND_BITS-SAMPLE_BITS+1){rsh[RND_BITS-1]}}) begin
      y_sat = rsh[RND_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                              : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      y_sat = rsh[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0]  <= A1_RESET;
      coef_r[1]  <= A2_RESET;
      coef_r[2]  <= B0_RESET;
      coef_r[3]  <= B1_RESET;
      coef_r[4]  <= B2_RESET;
      prod_vld_r <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        delay_first_r[i]  <= '0;
        delay_second_r[i] <= '0;
      end
    end else begin
      if (cfg_wr.we && (cfg_wr.idx < IDX_BITS'(REG_COUNT))) begin
        coef_r[cfg_wr.idx] <= cfg_wr.data;
      end
      prod_vld_r <= (cmd.op == OP_MUL);
      if (cmd.op == OP_ROUND_Y) begin
        delay_first_r[cmd.sec]  <= w0_r;
        delay_second_r[cmd.sec] <= d1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    prod_hi_r <= cmd.hi;
    case (cmd.op)
      OP_LOAD_IN: begin
        x_r <= sample_in;
      end
      OP_LOAD_SEC: begin
        d1_r  <= delay_first_r[cmd.sec];
        d2_r  <= delay_second_r[cmd.sec];
        acc_r <= ACC_BITS'(x_r) <<< FRAC_BITS;
      end
      OP_ROUND_W: begin
        w0_r  <= w0_sat;
        acc_r <= '0;
      end
      OP_ROUND_Y: begin
        x_r <= y_sat;
      end
      OP_EMIT: begin
        sample_out_r <= x_r;
      end
      default: begin
        if (prod_vld_r) begin
          acc_r <= acc_sum;
        end
      end
    endcase
  end

endmodule
